FILE: src/chol_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the 3x3 Cholesky solver.
// Used by every module of the block; depends on nothing.
package chol_pkg;

    localparam int CHOL_DATA_WIDTH = 32;
    localparam int CHOL_FRAC_BITS  = 16;
    localparam int CHOL_IN_FIELDS  = 9;
    localparam int CHOL_OUT_FIELDS = 3;

endpackage

FILE: src/cholesky_solve_3x3.sv
`timescale 1ns / 1ps
// Pipelined 3x3 Cholesky solver for A x = -b in signed fixed point.
// Depends on chol_pkg, chol_dly, chol_mul, chol_div and chol_sqrt.
//
// Usage:
//   The slave channel takes one item per handshake: the lower triangle of A
//   (a_00, a_10, a_11, a_20, a_21, a_22) and b (b_0, b_1, b_2), DATA_WIDTH bits
//   each, packed from the lowest bit in that order. The master channel returns
//   x_0, x_1, x_2 in m_tdata and the not_positive_definite flag in m_tuser;
//   when the flag is set, all three x fields are zero.
//   Throughput is one item per cycle while the output is not stalled. The
//   latency is set by the dependent chain of three square roots, six
//   divisions and four multiplies, plus the output register.
//   The whole pipeline advances on one enable; when the receiver holds the
//   output item, every stage holds and s_tready drops, so nothing is lost or
//   repeated. Synchronous reset clears the valid bits only; the data
//   registers are not reset.
module cholesky_solve_3x3 import chol_pkg::*; #(
    parameter int DATA_WIDTH = CHOL_DATA_WIDTH,
    parameter int FRAC_BITS  = CHOL_FRAC_BITS
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // a_00, a_10, a_11, a_20, a_21, a_22, b_0, b_1, b_2 from the lowest bit up
    input  logic [((CHOL_IN_FIELDS*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // x_0, x_1, x_2 from the lowest bit up
    output logic [((CHOL_OUT_FIELDS*DATA_WIDTH+7)/8)*8-1:0] m_tdata,
    // not_positive_definite
    output logic [0:0] m_tuser
);

    localparam int W  = DATA_WIDTH;
    localparam int OW = ((CHOL_OUT_FIELDS * W + 7) / 8) * 8;
    localparam int S  = (W + FRAC_BITS + 1) / 2 + 3;
    localparam int D  = W + 4;
    localparam int M  = 2;
    localparam int TA = S + D;
    localparam int TB = TA + M;
    localparam int TC = TB + S;
    localparam int TD = TC + D;
    localparam int TE = TD + M;
    localparam int TF = TE + S;
    localparam int TG = TF + D;
    localparam int TH = TG + D;
    localparam int TI = TH + M;
    localparam int TJ = TI + D;
    localparam int TK = TJ + M;
    localparam int TL = TK + D;

    function automatic logic signed [W-1:0] qsub(input logic signed [W-1:0] x,
                                                 input logic signed [W-1:0] y);
        logic [W:0] df;
        df = {x[W-1], x} - {y[W-1], y};
        if (df[W] != df[W-1]) begin
            return df[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
        return df[W-1:0];
    endfunction

    logic en;
    logic [TL:0] vld_reg;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[TL-1:0], s_tvalid};
        end
    end

    assign m_tvalid = vld_reg[TL];

    logic signed [W-1:0] a00, a10, a11, a20, a21, a22, nb0, nb1, nb2;
    assign a00 = s_tdata[0*W +: W];
    assign a10 = s_tdata[1*W +: W];
    assign a11 = s_tdata[2*W +: W];
    assign a20 = s_tdata[3*W +: W];
    assign a21 = s_tdata[4*W +: W];
    assign a22 = s_tdata[5*W +: W];
    assign nb0 = qsub('0, s_tdata[6*W +: W]);
    assign nb1 = qsub('0, s_tdata[7*W +: W]);
    assign nb2 = qsub('0, s_tdata[8*W +: W]);

    // Factor: first column, and the first row of the forward pass.
    logic signed [W-1:0] l00, a10_d, a20_d, nb0_d, l10, l20, y0;
    chol_sqrt #(.W(W), .F(FRAC_BITS)) u_sq0 (.aclk, .en, .a(a00), .r(l00));
    chol_dly #(.W(W), .N(S)) u_d_a10 (.aclk, .en, .din(a10), .dout(a10_d));
    chol_dly #(.W(W), .N(S)) u_d_a20 (.aclk, .en, .din(a20), .dout(a20_d));
    chol_dly #(.W(W), .N(S)) u_d_nb0 (.aclk, .en, .din(nb0), .dout(nb0_d));
    chol_div #(.W(W), .F(FRAC_BITS)) u_dv_l10 (.aclk, .en, .n(a10_d), .d(l00), .q(l10));
    chol_div #(.W(W), .F(FRAC_BITS)) u_dv_l20 (.aclk, .en, .n(a20_d), .d(l00), .q(l20));
    chol_div #(.W(W), .F(FRAC_BITS)) u_dv_y0 (.aclk, .en, .n(nb0_d), .d(l00), .q(y0));

    logic signed [W-1:0] m_l10sq, m_l20l10, m_l20sq, m_l10y0, m_l20y0;
    chol_mul #(.W(W), .F(FRAC_BITS)) u_m0 (.aclk, .en, .a(l10), .b(l10), .p(m_l10sq));
    chol_mul #(.W(W), .F(FRAC_BITS)) u_m1 (.aclk, .en, .a(l20), .b(l10), .p(m_l20l10));
    chol_mul #(.W(W), .F(FRAC_BITS)) u_m2 (.aclk, .en, .a(l20), .b(l20), .p(m_l20sq));
    chol_mul #(.W(W), .F(FRAC_BITS)) u_m3 (.aclk, .en, .a(l10), .b(y0), .p(m_l10y0));
    chol_mul #(.W(W), .F(FRAC_BITS)) u_m4 (.aclk, .en, .a(l20), .b(y0), .p(m_l20y0));

    logic signed [W-1:0] a11_d, a21_d, a22_d, nb1_d, nb2_d, p1, t21, t1, q22, u2;
    chol_dly #(.W(W), .N(TB)) u_d_a11 (.aclk, .en, .din(a11), .dout(a11_d));
    chol_dly #(.W(W), .N(TB)) u_d_a21 (.aclk, .en, .din(a21), .dout(a21_d));
    chol_dly #(.W(W), .N(TB)) u_d_a22 (.aclk, .en, .din(a22), .dout(a22_d));
    chol_dly #(.W(W), .N(TB)) u_d_nb1 (.aclk, .en, .din(nb1), .dout(nb1_d));
    chol_dly #(.W(W), .N(TB)) u_d_nb2 (.aclk, .en, .din(nb2), .dout(nb2_d));
    assign p1  = qsub(a11_d, m_l10sq);
    assign t21 = qsub(a21_d, m_l20l10);
    assign t1  = qsub(nb1_d, m_l10y0);
    assign q22 = qsub(a22_d, m_l20sq);
    assign u2  = qsub(nb2_d, m_l20y0);

    // Second column and the middle row of the forward pass.
    logic signed [W-1:0] l11, t21_d, t1_d, l21, y1;
    chol_sqrt #(.W(W), .F(FRAC_BITS)) u_sq1 (.aclk, .en, .a(p1), .r(l11));
    chol_dly #(.W(W), .N(S)) u_d_t21 (.aclk, .en, .din(t21), .dout(t21_d));
    chol_dly #(.W(W), .N(S)) u_d_t1 (.aclk, .en, .din(t1), .dout(t1_d));
    chol_div #(.W(W), .F(FRAC_BITS)) u_dv_l21 (.aclk, .en, .n(t21_d), .d(l11), .q(l21));
    chol_div #(.W(W), .F(FRAC_BITS)) u_dv_y1 (.aclk, .en, .n(t1_d), .d(l11), .q(y1));

    logic signed [W-1:0] m_l21sq, m_l21y1, q22_d, u2_d, p2, v2;
    chol_mul #(.W(W), .F(FRAC_BITS)) u_m5 (.aclk, .en, .a(l21), .b(l21), .p(m_l21sq));
    chol_mul #(.W(W), .F(FRAC_BITS)) u_m6 (.aclk, .en, .a(l21), .b(y1), .p(m_l21y1));
    chol_dly #(.W(W), .N(TE-TB)) u_d_q22 (.aclk, .en, .din(q22), .dout(q22_d));
    chol_dly #(.W(W), .N(TE-TB)) u_d_u2 (.aclk, .en, .din(u2), .dout(u2_d));
    assign p2 = qsub(q22_d, m_l21sq);
    assign v2 = qsub(u2_d, m_l21y1);

    // Last pivot, last forward row, then back substitution from the bottom.
    logic signed [W-1:0] l22, v2_d, y2, l22_d, x2;
    chol_sqrt #(.W(W), .F(FRAC_BITS)) u_sq2 (.aclk, .en, .a(p2), .r(l22));
    chol_dly #(.W(W), .N(S)) u_d_v2 (.aclk, .en, .din(v2), .dout(v2_d));
    chol_div #(.W(W), .F(FRAC_BITS)) u_dv_y2 (.aclk, .en, .n(v2_d), .d(l22), .q(y2));
    chol_dly #(.W(W), .N(D)) u_d_l22 (.aclk, .en, .din(l22), .dout(l22_d));
    chol_div #(.W(W), .F(FRAC_BITS)) u_dv_x2 (.aclk, .en, .n(y2), .d(l22_d), .q(x2));

    logic signed [W-1:0] l21_d, l20_d, m_l21x2, m_l20x2, y1_d, y0_d, l11_d, w1;
    logic signed [W-1:0] m_l20x2_d, x1;
    chol_dly #(.W(W), .N(TH-TD)) u_d_l21 (.aclk, .en, .din(l21), .dout(l21_d));
    chol_dly #(.W(W), .N(TH-TA)) u_d_l20 (.aclk, .en, .din(l20), .dout(l20_d));
    chol_mul #(.W(W), .F(FRAC_BITS)) u_m7 (.aclk, .en, .a(l21_d), .b(x2), .p(m_l21x2));
    chol_mul #(.W(W), .F(FRAC_BITS)) u_m8 (.aclk, .en, .a(l20_d), .b(x2), .p(m_l20x2));
    chol_dly #(.W(W), .N(TI-TD)) u_d_y1 (.aclk, .en, .din(y1), .dout(y1_d));
    chol_dly #(.W(W), .N(TK-TA)) u_d_y0 (.aclk, .en, .din(y0), .dout(y0_d));
    chol_dly #(.W(W), .N(TI-TC)) u_d_l11 (.aclk, .en, .din(l11), .dout(l11_d));
    assign w1 = qsub(y1_d, m_l21x2);
    chol_div #(.W(W), .F(FRAC_BITS)) u_dv_x1 (.aclk, .en, .n(w1), .d(l11_d), .q(x1));
    chol_dly #(.W(W), .N(TK-TI)) u_d_m20 (.aclk, .en, .din(m_l20x2), .dout(m_l20x2_d));

    // The top row subtracts the l10 term first, then the l20 term.
    logic signed [W-1:0] l10_d, m_l10x1, z0, z1, l00_d, x0, x1_d, x2_d;
    chol_dly #(.W(W), .N(TJ-TA)) u_d_l10 (.aclk, .en, .din(l10), .dout(l10_d));
    chol_mul #(.W(W), .F(FRAC_BITS)) u_m9 (.aclk, .en, .a(l10_d), .b(x1), .p(m_l10x1));
    assign z0 = qsub(y0_d, m_l10x1);
    assign z1 = qsub(z0, m_l20x2_d);
    chol_dly #(.W(W), .N(TK-S)) u_d_l00 (.aclk, .en, .din(l00), .dout(l00_d));
    chol_div #(.W(W), .F(FRAC_BITS)) u_dv_x0 (.aclk, .en, .n(z1), .d(l00_d), .q(x0));
    chol_dly #(.W(W), .N(TL-TJ)) u_d_x1 (.aclk, .en, .din(x1), .dout(x1_d));
    chol_dly #(.W(W), .N(TL-TH)) u_d_x2 (.aclk, .en, .din(x2), .dout(x2_d));

    // Pivot checks travel alongside the data and blank the result at the end.
    logic npd0, npd1, npd2, npd0_d, npd1_d, npd2_d, npd;
    assign npd0 = a00[W-1] || (a00 == '0);
    assign npd1 = p1[W-1] || (p1 == '0);
    assign npd2 = p2[W-1] || (p2 == '0);
    chol_dly #(.W(1), .N(TL)) u_d_npd0 (.aclk, .en, .din(npd0), .dout(npd0_d));
    chol_dly #(.W(1), .N(TL-TB)) u_d_npd1 (.aclk, .en, .din(npd1), .dout(npd1_d));
    chol_dly #(.W(1), .N(TL-TE)) u_d_npd2 (.aclk, .en, .din(npd2), .dout(npd2_d));
    assign npd = npd0_d || npd1_d || npd2_d;

    logic [3*W-1:0] x_reg;
    logic           npd_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg   <= npd ? '0 : {x2_d, x1_d, x0};
            npd_reg <= npd;
        end
    end

    assign m_tdata = OW'(x_reg);
    assign m_tuser = npd_reg;

    a_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (x_reg == '0))
        else $error("flagged item carries nonzero solution");

    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted item did not enter the pipeline");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(vld_reg) && $stable(x_reg))
        else $error("pipeline moved while the output was stalled");

endmodule

FILE: src/chol_dly.sv
`timescale 1ns / 1ps
// Enabled delay line of N register stages, or a plain wire when N is 0.
// Depends on chol_pkg for the default width.
module chol_dly import chol_pkg::*; #(
    parameter int W = CHOL_DATA_WIDTH,
    parameter int N = 1
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    generate
        if (N == 0) begin : g_none
            assign dout = din;
        end else begin : g_line
            logic [W-1:0] tap_reg [N];
            always_ff @(posedge aclk) begin
                if (en) begin
                    tap_reg[0] <= din;
                    for (int i = 1; i < N; i++) begin
                        tap_reg[i] <= tap_reg[i-1];
                    end
                end
            end
            assign dout = tap_reg[N-1];
        end
    endgenerate

endmodule

FILE: src/chol_mul.sv
`timescale 1ns / 1ps
// Two-stage fixed-point multiplier: magnitude product, then rounding and saturation.
// Depends on chol_pkg for defaults.
module chol_mul import chol_pkg::*; #(
    parameter int W = CHOL_DATA_WIDTH,
    parameter int F = CHOL_FRAC_BITS
) (
    input  logic                aclk,
    input  logic                en,
    input  logic signed [W-1:0] a,
    input  logic signed [W-1:0] b,
    output logic signed [W-1:0] p
);

    localparam int SW = 2 * W + 1;
    localparam int MW = SW - F;

    logic [W-1:0]   ua, ub;
    logic [2*W-1:0] prod_reg;
    logic           neg_reg;
    logic [SW-1:0]  sum;
    logic [MW-1:0]  mg, lim;
    logic [W-1:0]   res;
    logic signed [W-1:0] p_reg;

    assign ua = a[W-1] ? (~a + 1'b1) : a;
    assign ub = b[W-1] ? (~b + 1'b1) : b;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= ua * ub;
            neg_reg  <= a[W-1] ^ b[W-1];
        end
    end

    always_comb begin
        sum = SW'(prod_reg) + (SW'(1) << (F - 1));
        mg  = sum[SW-1:F];
        lim = (MW'(1) << (W - 1)) - MW'(!neg_reg);
        if (mg > lim) begin
            mg = lim;
        end
        res = neg_reg ? (~mg[W-1:0] + 1'b1) : mg[W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= res;
        end
    end

    assign p = p_reg;

endmodule

FILE: src/chol_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider for fixed point, one quotient bit per stage,
// rounded to nearest (ties away from zero) and saturated. Depends on chol_pkg.
module chol_div import chol_pkg::*; #(
    parameter int W = CHOL_DATA_WIDTH,
    parameter int F = CHOL_FRAC_BITS
) (
    input  logic                aclk,
    input  logic                en,
    input  logic signed [W-1:0] n,
    input  logic signed [W-1:0] d,
    output logic signed [W-1:0] q
);

    localparam int QB = W + 1;
    localparam int NW = W + F;
    localparam int HW = F - 1;
    localparam int CW = (HW > W) ? HW : W;

    logic signed [W-1:0] n_reg, d_reg;
    logic [W-1:0]  un, ud;
    logic [NW-1:0] nn;
    logic [HW-1:0] hi;

    logic [W-1:0]  rem_reg  [QB+1];
    logic [QB-1:0] lo_reg   [QB+1];
    logic [QB-1:0] quo_reg  [QB+1];
    logic [W-1:0]  ud_reg   [QB+1];
    logic          neg_reg  [QB+1];
    logic          over_reg [QB+1];
    logic          zero_reg [QB+1];
    logic          nneg_reg [QB+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg <= n;
            d_reg <= d;
        end
    end

    assign un = n_reg[W-1] ? (~n_reg + 1'b1) : n_reg;
    assign ud = d_reg[W-1] ? (~d_reg + 1'b1) : d_reg;
    assign nn = {un, {F{1'b0}}};
    assign hi = nn[NW-1:QB];

    // The top bits of the dividend form the starting remainder; if they already
    // reach the divisor, the quotient cannot fit and saturates.
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= W'(hi);
            lo_reg[0]   <= nn[QB-1:0];
            quo_reg[0]  <= '0;
            ud_reg[0]   <= ud;
            neg_reg[0]  <= n_reg[W-1] ^ d_reg[W-1];
            over_reg[0] <= CW'(hi) >= CW'(ud);
            zero_reg[0] <= (ud == '0);
            nneg_reg[0] <= n_reg[W-1];
        end
    end

    generate
        for (genvar k = 0; k < QB; k++) begin : g_step
            logic [W:0] r2, diff;
            logic       ge;
            always_comb begin
                r2   = {rem_reg[k], lo_reg[k][QB-1-k]};
                ge   = r2 >= {1'b0, ud_reg[k]};
                diff = r2 - {1'b0, ud_reg[k]};
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k+1]  <= ge ? diff[W-1:0] : r2[W-1:0];
                    lo_reg[k+1]   <= lo_reg[k];
                    quo_reg[k+1]  <= {quo_reg[k][QB-2:0], ge};
                    ud_reg[k+1]   <= ud_reg[k];
                    neg_reg[k+1]  <= neg_reg[k];
                    over_reg[k+1] <= over_reg[k];
                    zero_reg[k+1] <= zero_reg[k];
                    nneg_reg[k+1] <= nneg_reg[k];
                end
            end
        end
    endgenerate

    logic          rup;
    logic [QB:0]   sum, lim, mg;
    logic [W-1:0]  res;
    logic signed [W-1:0] q_reg;

    always_comb begin
        rup = {rem_reg[QB], 1'b0} >= {1'b0, ud_reg[QB]};
        sum = (QB+1)'(quo_reg[QB]) + (QB+1)'(rup);
        lim = ((QB+1)'(1) << (W - 1)) - (QB+1)'(!neg_reg[QB]);
        mg  = (over_reg[QB] || (sum > lim)) ? lim : sum;
        res = neg_reg[QB] ? (~mg[W-1:0] + 1'b1) : mg[W-1:0];
        if (zero_reg[QB]) begin
            res = nneg_reg[QB] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= res;
        end
    end

    assign q = q_reg;

endmodule

FILE: src/chol_sqrt.sv
`timescale 1ns / 1ps
// Pipelined digit-by-digit square root, floor(sqrt(|a| * 2^F)), one root bit
// per stage, saturated to the positive bound. Depends on chol_pkg.
module chol_sqrt import chol_pkg::*; #(
    parameter int W = CHOL_DATA_WIDTH,
    parameter int F = CHOL_FRAC_BITS
) (
    input  logic                aclk,
    input  logic                en,
    input  logic signed [W-1:0] a,
    output logic signed [W-1:0] r
);

    localparam int RB = (W + F + 1) / 2;
    localparam int VW = 2 * RB;
    localparam int RW = RB + 2;
    localparam int CW = (RB > W) ? RB : W;

    logic signed [W-1:0] a_reg;
    logic [W-1:0]  ua;

    logic [VW-1:0] v_reg    [RB+1];
    logic [RW-1:0] rem_reg  [RB+1];
    logic [RB-1:0] root_reg [RB+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg <= a;
        end
    end

    assign ua = a_reg[W-1] ? (~a_reg + 1'b1) : a_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg[0]    <= VW'({ua, {F{1'b0}}});
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
        end
    end

    generate
        for (genvar k = 0; k < RB; k++) begin : g_step
            logic [RW+1:0] r4, trial, diff;
            logic          ge;
            always_comb begin
                r4    = {rem_reg[k], v_reg[k][VW-1-2*k -: 2]};
                trial = (RW+2)'({root_reg[k], 2'b01});
                ge    = r4 >= trial;
                diff  = r4 - trial;
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    v_reg[k+1]    <= v_reg[k];
                    rem_reg[k+1]  <= ge ? diff[RW-1:0] : r4[RW-1:0];
                    root_reg[k+1] <= {root_reg[k][RB-2:0], ge};
                end
            end
        end
    endgenerate

    logic [CW-1:0] rt, lim;
    logic signed [W-1:0] r_reg;

    always_comb begin
        rt  = CW'(root_reg[RB]);
        lim = (CW'(1) << (W - 1)) - CW'(1);
        if (rt > lim) begin
            rt = lim;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg <= rt[W-1:0];
        end
    end

    assign r = r_reg;

endmodule
